/* sv/dbwq_pkg.sv */
`timescale 1ns / 1ps

package dbwq_pkg;

  localparam int NUM_ENTRIES_DEF = 256;
  localparam int MARK_COUNT      = 256;
  localparam int IDX_W           = 8;
  localparam int FRAME_W         = 32;
  localparam int BUDGET_W        = 6;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(3);

  localparam logic REQ_ENQ   = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENQ,
    ST_RD,
    ST_POP
  } state_t;

endpackage

/* sv/dbwq_req_if.sv */
`timescale 1ns / 1ps

interface dbwq_req_if import dbwq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [IDX_W-1:0]   entry_index;
  logic [FRAME_W-1:0] current_frame;

  modport source (output valid, output req_type, output entry_index,
                  output current_frame, input ready);
  modport sink (input valid, input req_type, input entry_index,
                input current_frame, output ready);
endinterface

/* sv/dbwq_res_if.sv */
`timescale 1ns / 1ps

interface dbwq_res_if import dbwq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] drained_index;
  logic             last_of_run;

  modport source (output valid, output drained_index, output last_of_run, input ready);
  modport sink (input valid, input drained_index, input last_of_run, output ready);
endinterface

/* sv/dedup_budgeted_work_queue_unit.sv */
`timescale 1ns / 1ps

// Deduplicating work queue with a per-frame drain budget. One request is in
// flight at a time: an enqueue does a pending-mark memory read, then the check
// and the writes; a drain request that is blocked or finds the queue empty is
// done on acceptance; and a drain pass does, for each emitted word, a queue
// memory read of the head slot, then pop, mark clear and output load, with the
// pop waiting while the output register stays full. A result word waits in the
// output register, and new requests are taken while it waits. Budget writes of
// zero are ignored.
module dedup_budgeted_work_queue_unit import dbwq_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [BUDGET_W-1:0] cfg_wr_data,
  dbwq_req_if.sink            req,
  dbwq_res_if.source          res
);

  localparam int PTR_W = $clog2(NUM_ENTRIES);
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
  localparam int SUM_W = PTR_W + 1;
  localparam int MARK_W = $clog2(MARK_COUNT);

  state_t state, state_next;

  logic [PTR_W-1:0]    head;
  logic [CNT_W-1:0]    count;
  logic [FRAME_W-1:0]  enq_frame;
  logic                enq_frame_vld;
  logic [FRAME_W-1:0]  proc_frame;
  logic                proc_frame_vld;
  logic [BUDGET_W-1:0] budget;
  logic [BUDGET_W-1:0] emitted;
  logic [IDX_W-1:0]    idx_reg;
  logic [FRAME_W-1:0]  frame_reg;
  logic [MARK_COUNT-1:0] mark_vld;

  logic                req_acc;
  logic                drain_ok;
  logic                slot_free;
  logic                is_marked;
  logic                full;
  logic                enq_fire;
  logic                pop_fire;
  logic                pop_last;
  logic                mark_re;
  logic                fifo_re;
  logic                mark_we;
  logic [MARK_W-1:0]   mark_waddr;
  logic [0:0]          mark_q;
  logic [IDX_W-1:0]    fifo_q;
  logic [SUM_W-1:0]    tail_sum;
  logic [PTR_W-1:0]    tail;
  logic [PTR_W-1:0]    head_inc;
  logic [BUDGET_W-1:0] emitted_inc;

  assign req.ready = (state == ST_IDLE);
  assign req_acc   = req.valid && req.ready;

  assign drain_ok = (count != '0)
                    && !(proc_frame_vld && proc_frame == req.current_frame)
                    && !(enq_frame_vld && enq_frame == req.current_frame);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_acc) begin
          if (req.req_type == REQ_ENQ) begin
            state_next = ST_ENQ;
          end else if (drain_ok) begin
            state_next = ST_RD;
          end
        end
      end
      ST_ENQ: state_next = ST_IDLE;
      ST_RD:  state_next = ST_POP;
      ST_POP: begin
        if (slot_free) begin
          state_next = pop_last ? ST_IDLE : ST_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    slot_free   = !res.valid || res.ready;
    mark_re     = req_acc && (req.req_type == REQ_ENQ);
    fifo_re     = (state == ST_RD);
    is_marked   = mark_q[0] && mark_vld[idx_reg];
    full        = (count == CNT_W'(NUM_ENTRIES));
    enq_fire    = (state == ST_ENQ) && !is_marked && !full;
    pop_fire    = (state == ST_POP) && slot_free;
    emitted_inc = emitted + BUDGET_W'(1);
    pop_last    = (emitted_inc == budget) || (count == CNT_W'(1));
    mark_we     = enq_fire || pop_fire;
    mark_waddr  = enq_fire ? idx_reg : fifo_q;
    tail_sum    = SUM_W'(head) + SUM_W'(count);
    tail        = (tail_sum >= SUM_W'(NUM_ENTRIES))
                  ? PTR_W'(tail_sum - SUM_W'(NUM_ENTRIES)) : PTR_W'(tail_sum);
    head_inc    = (head == PTR_W'(NUM_ENTRIES - 1)) ? '0 : head + PTR_W'(1);
  end

  dbwq_ram #(
    .WIDTH (1),
    .DEPTH (MARK_COUNT)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (enq_fire),
    .re    (mark_re),
    .raddr (req.entry_index),
    .rdata (mark_q)
  );

  dbwq_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_ENTRIES)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (enq_fire),
    .waddr (tail),
    .wdata (idx_reg),
    .re    (fifo_re),
    .raddr (head),
    .rdata (fifo_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      head           <= '0;
      count          <= '0;
      enq_frame_vld  <= 1'b0;
      proc_frame_vld <= 1'b0;
      budget         <= BUDGET_RESET;
      emitted        <= '0;
      mark_vld       <= '0;
      res.valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en && cfg_wr_data != '0) begin
        budget <= cfg_wr_data;
      end
      if (req_acc && req.req_type == REQ_DRAIN) begin
        proc_frame_vld <= 1'b1;
        emitted        <= '0;
      end
      if (enq_fire) begin
        mark_vld[idx_reg] <= 1'b1;
        count             <= count + CNT_W'(1);
        enq_frame_vld     <= 1'b1;
      end
      if (pop_fire) begin
        // queue emptied: restart at slot zero
        head      <= (count == CNT_W'(1)) ? '0 : head_inc;
        count     <= count - CNT_W'(1);
        emitted   <= emitted_inc;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      idx_reg   <= req.entry_index;
      frame_reg <= req.current_frame;
      if (req.req_type == REQ_DRAIN) begin
        proc_frame <= req.current_frame;
      end
    end
    if (enq_fire) begin
      enq_frame <= frame_reg;
    end
    if (pop_fire) begin
      res.drained_index <= fifo_q;
      res.last_of_run   <= pop_last;
    end
  end

endmodule

/* sv/dbwq_ram.sv */
`timescale 1ns / 1ps

module dbwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/dbwq_checker.sv */
`timescale 1ns / 1ps

module dbwq_checker import dbwq_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             req_type,
  input logic             res_valid,
  input logic             res_ready,
  input logic [IDX_W-1:0] drained_index,
  input logic             last_of_run
);

  // a stalled result word stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(drained_index) && $stable(last_of_run))
    else $error("result payload changed while stalled");

  // one request at a time: ready drops after an enqueue is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_type == REQ_ENQ |=> !req_ready)
    else $error("request taken while another is in flight");

  // an enqueue never produces a word
  a_enq_no_word: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_type == REQ_ENQ |=> !$rose(res_valid))
    else $error("word emitted right after an enqueue");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind dedup_budgeted_work_queue_unit dbwq_checker u_dbwq_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_type      (req.req_type),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .drained_index (res.drained_index),
  .last_of_run   (res.last_of_run)
);
